// ===== hw/rtl/rtr_pkg.sv =====
package rtr_pkg;

    // 64-bit saturation limits
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    // configuration register indexes
    localparam logic [2:0] CFG_REF     = 3'd0;
    localparam logic [2:0] CFG_FS      = 3'd1;
    localparam logic [2:0] CFG_R0      = 3'd2;
    localparam logic [2:0] CFG_A_HOT   = 3'd3;
    localparam logic [2:0] CFG_B_HOT   = 3'd4;
    localparam logic [2:0] CFG_A_COLD  = 3'd5;
    localparam logic [2:0] CFG_B_COLD  = 3'd6;
    localparam logic [2:0] CFG_C_COLD  = 3'd7;

    // reset values of the configuration registers
    localparam logic [15:0]        RST_REF    = 16'd430;
    localparam logic [15:0]        RST_FS     = 16'd32768;
    localparam logic [19:0]        RST_R0     = 20'd10000;
    localparam logic [30:0]        RST_A_HOT  = 31'd3908300;
    localparam logic signed [20:0] RST_B_HOT  = -21'sd578;
    localparam logic [26:0]        RST_A_COLD = 27'd39083;
    localparam logic signed [27:0] RST_B_COLD = -28'sd5775;
    localparam logic signed [27:0] RST_C_COLD = -28'sd4183;

    typedef struct packed {
        logic [15:0]        ref_ohms;
        logic [15:0]        full_scale;
        logic [19:0]        r0_x100;
        logic [30:0]        a_hot;
        logic signed [20:0] b_hot;
        logic [26:0]        a_cold;
        logic signed [27:0] b_cold;
        logic signed [27:0] c_cold;
    } t_cfg;

    // status from the core to the top level
    typedef struct packed {
        logic        done;
        logic [14:0] temp;
        logic [30:0] res;
    } t_res;

    // micro-ops
    typedef enum logic [3:0] {
        OP_MUL, OP_DIV, OP_ADD, OP_SUB, OP_CLR, OP_CLI, OP_WRP, OP_CLRS,
        OP_FIN, OP_BNEG, OP_BZ, OP_LHOT, OP_LCOLD, OP_LOOP
    } t_op;

    // literal operands: configuration values and constants
    typedef enum logic [4:0] {
        K_CODE, K_REF, K_DIV, K_R0, K_AH, K_BH, K_AC, K_BC, K_CC,
        K_2, K_4, K_10, K_100, K_1000, K_3000, K_10000,
        K_E8, K_E9, K_E10, K_E11
    } t_lit;

    typedef struct packed {
        logic       lit;
        logic [4:0] idx;
    } t_opd;

    typedef struct packed {
        t_op        op;
        logic [3:0] dst;
        t_opd       a;
        t_opd       b;
        logic [6:0] tgt;
    } t_uop;

    // scratch slots
    localparam logic [3:0] SL_R    = 4'd0;
    localparam logic [3:0] SL_DIFF = 4'd1;
    localparam logic [3:0] SL_P    = 4'd2;
    localparam logic [3:0] SL_X    = 4'd3;
    localparam logic [3:0] SL_T    = 4'd4;
    localparam logic [3:0] SL_U    = 4'd5;
    localparam logic [3:0] SL_V    = 4'd6;
    localparam logic [3:0] SL_W    = 4'd7;
    localparam logic [3:0] SL_Y    = 4'd8;
    localparam logic [3:0] SL_Z    = 4'd9;

    // branch targets
    localparam logic [6:0] PC_NONE      = 7'd0;
    localparam logic [6:0] PC_HOT_LOOP  = 7'd13;
    localparam logic [6:0] PC_HOT_END   = 7'd34;
    localparam logic [6:0] PC_COLD      = 7'd35;
    localparam logic [6:0] PC_COLD_LOOP = 7'd38;
    localparam logic [6:0] PC_COLD_NEXT = 7'd75;

    function automatic t_opd sl(logic [3:0] n);
        t_opd o;
        o.lit = 1'b0;
        o.idx = {1'b0, n};
        return o;
    endfunction

    function automatic t_opd lt(t_lit k);
        t_opd o;
        o.lit = 1'b1;
        o.idx = k;
        return o;
    endfunction

    function automatic t_uop uo(t_op op, logic [3:0] dst, t_opd a, t_opd b,
                                logic [6:0] tgt);
        t_uop u;
        u.op  = op;
        u.dst = dst;
        u.a   = a;
        u.b   = b;
        u.tgt = tgt;
        return u;
    endfunction

    // microcode: resistance, then hot or cold Newton iteration
    function automatic t_uop rtr_rom(logic [6:0] pc);
        t_uop u;
        case (pc)
            // resistance x100
            7'd0:  u = uo(OP_MUL,  SL_R, lt(K_CODE), lt(K_REF), PC_NONE);
            7'd1:  u = uo(OP_MUL,  SL_R, sl(SL_R), lt(K_100), PC_NONE);
            7'd2:  u = uo(OP_DIV,  SL_R, sl(SL_R), lt(K_DIV), PC_NONE);
            7'd3:  u = uo(OP_CLRS, SL_R, sl(SL_R), sl(SL_R), PC_NONE);
            7'd4:  u = uo(OP_SUB,  SL_DIFF, sl(SL_R), lt(K_10000), PC_NONE);
            7'd5:  u = uo(OP_BNEG, SL_R, sl(SL_DIFF), sl(SL_DIFF), PC_COLD);
            // hot: linear estimate
            7'd6:  u = uo(OP_MUL,  SL_P, lt(K_R0), lt(K_AH), PC_NONE);
            7'd7:  u = uo(OP_SUB,  SL_X, sl(SL_R), lt(K_R0), PC_NONE);
            7'd8:  u = uo(OP_MUL,  SL_X, sl(SL_X), lt(K_10), PC_NONE);
            7'd9:  u = uo(OP_MUL,  SL_X, sl(SL_X), lt(K_E9), PC_NONE);
            7'd10: u = uo(OP_DIV,  SL_X, sl(SL_X), sl(SL_P), PC_NONE);
            7'd11: u = uo(OP_CLR,  SL_T, sl(SL_X), sl(SL_X), PC_NONE);
            7'd12: u = uo(OP_LHOT, SL_T, sl(SL_T), sl(SL_T), PC_NONE);
            // hot: Newton step
            7'd13: u = uo(OP_MUL,  SL_U, sl(SL_P), sl(SL_T), PC_NONE);
            7'd14: u = uo(OP_DIV,  SL_U, sl(SL_U), lt(K_E10), PC_NONE);
            7'd15: u = uo(OP_MUL,  SL_V, lt(K_R0), lt(K_BH), PC_NONE);
            7'd16: u = uo(OP_MUL,  SL_W, sl(SL_T), sl(SL_T), PC_NONE);
            7'd17: u = uo(OP_MUL,  SL_V, sl(SL_V), sl(SL_W), PC_NONE);
            7'd18: u = uo(OP_DIV,  SL_V, sl(SL_V), lt(K_E11), PC_NONE);
            7'd19: u = uo(OP_ADD,  SL_W, lt(K_R0), sl(SL_U), PC_NONE);
            7'd20: u = uo(OP_ADD,  SL_W, sl(SL_W), sl(SL_V), PC_NONE);
            7'd21: u = uo(OP_SUB,  SL_W, sl(SL_W), sl(SL_R), PC_NONE);
            7'd22: u = uo(OP_MUL,  SL_Y, lt(K_R0), lt(K_2), PC_NONE);
            7'd23: u = uo(OP_MUL,  SL_Y, sl(SL_Y), lt(K_BH), PC_NONE);
            7'd24: u = uo(OP_MUL,  SL_Y, sl(SL_Y), sl(SL_T), PC_NONE);
            7'd25: u = uo(OP_DIV,  SL_Y, sl(SL_Y), lt(K_E11), PC_NONE);
            7'd26: u = uo(OP_DIV,  SL_Z, sl(SL_P), lt(K_E10), PC_NONE);
            7'd27: u = uo(OP_ADD,  SL_Y, sl(SL_Z), sl(SL_Y), PC_NONE);
            7'd28: u = uo(OP_BZ,   SL_Y, sl(SL_Y), sl(SL_Y), PC_HOT_END);
            7'd29: u = uo(OP_DIV,  SL_W, sl(SL_W), sl(SL_Y), PC_NONE);
            7'd30: u = uo(OP_WRP,  SL_W, sl(SL_W), sl(SL_W), PC_NONE);
            7'd31: u = uo(OP_SUB,  SL_T, sl(SL_T), sl(SL_W), PC_NONE);
            7'd32: u = uo(OP_CLR,  SL_T, sl(SL_T), sl(SL_T), PC_NONE);
            7'd33: u = uo(OP_LOOP, SL_T, sl(SL_T), sl(SL_T), PC_HOT_LOOP);
            7'd34: u = uo(OP_FIN,  SL_T, sl(SL_T), sl(SL_T), PC_NONE);
            // cold: initial estimate
            7'd35: u = uo(OP_MUL,  SL_DIFF, sl(SL_DIFF), lt(K_10000), PC_NONE);
            7'd36: u = uo(OP_DIV,  SL_T, sl(SL_DIFF), lt(K_AC), PC_NONE);
            7'd37: u = uo(OP_LCOLD, SL_T, sl(SL_T), sl(SL_T), PC_NONE);
            // cold: Newton step
            7'd38: u = uo(OP_MUL,  SL_P, sl(SL_T), sl(SL_T), PC_NONE);
            7'd39: u = uo(OP_DIV,  SL_P, sl(SL_P), lt(K_10), PC_NONE);
            7'd40: u = uo(OP_MUL,  SL_X, sl(SL_P), sl(SL_T), PC_NONE);
            7'd41: u = uo(OP_DIV,  SL_X, sl(SL_X), lt(K_10), PC_NONE);
            7'd42: u = uo(OP_MUL,  SL_U, lt(K_AC), sl(SL_T), PC_NONE);
            7'd43: u = uo(OP_MUL,  SL_U, sl(SL_U), lt(K_100), PC_NONE);
            7'd44: u = uo(OP_MUL,  SL_V, lt(K_BC), sl(SL_P), PC_NONE);
            7'd45: u = uo(OP_DIV,  SL_V, sl(SL_V), lt(K_10), PC_NONE);
            7'd46: u = uo(OP_SUB,  SL_W, sl(SL_T), lt(K_1000), PC_NONE);
            7'd47: u = uo(OP_MUL,  SL_W, lt(K_CC), sl(SL_W), PC_NONE);
            7'd48: u = uo(OP_MUL,  SL_W, sl(SL_W), sl(SL_X), PC_NONE);
            7'd49: u = uo(OP_DIV,  SL_W, sl(SL_W), lt(K_E8), PC_NONE);
            7'd50: u = uo(OP_ADD,  SL_U, lt(K_E10), sl(SL_U), PC_NONE);
            7'd51: u = uo(OP_ADD,  SL_U, sl(SL_U), sl(SL_V), PC_NONE);
            7'd52: u = uo(OP_ADD,  SL_U, sl(SL_U), sl(SL_W), PC_NONE);
            7'd53: u = uo(OP_MUL,  SL_U, lt(K_100), sl(SL_U), PC_NONE);
            7'd54: u = uo(OP_DIV,  SL_U, sl(SL_U), lt(K_E9), PC_NONE);
            7'd55: u = uo(OP_SUB,  SL_U, sl(SL_U), sl(SL_R), PC_NONE);
            7'd56: u = uo(OP_MUL,  SL_V, lt(K_AC), lt(K_100), PC_NONE);
            7'd57: u = uo(OP_MUL,  SL_W, lt(K_2), lt(K_BC), PC_NONE);
            7'd58: u = uo(OP_MUL,  SL_W, sl(SL_W), sl(SL_T), PC_NONE);
            7'd59: u = uo(OP_DIV,  SL_W, sl(SL_W), lt(K_10), PC_NONE);
            7'd60: u = uo(OP_MUL,  SL_Y, lt(K_4), sl(SL_X), PC_NONE);
            7'd61: u = uo(OP_MUL,  SL_Z, lt(K_3000), sl(SL_P), PC_NONE);
            7'd62: u = uo(OP_SUB,  SL_Y, sl(SL_Y), sl(SL_Z), PC_NONE);
            7'd63: u = uo(OP_MUL,  SL_Y, lt(K_CC), sl(SL_Y), PC_NONE);
            7'd64: u = uo(OP_DIV,  SL_Y, sl(SL_Y), lt(K_E8), PC_NONE);
            7'd65: u = uo(OP_ADD,  SL_V, sl(SL_V), sl(SL_W), PC_NONE);
            7'd66: u = uo(OP_ADD,  SL_V, sl(SL_V), sl(SL_Y), PC_NONE);
            7'd67: u = uo(OP_MUL,  SL_V, lt(K_100), sl(SL_V), PC_NONE);
            7'd68: u = uo(OP_DIV,  SL_V, sl(SL_V), lt(K_E9), PC_NONE);
            7'd69: u = uo(OP_BZ,   SL_V, sl(SL_V), sl(SL_V), PC_COLD_NEXT);
            7'd70: u = uo(OP_MUL,  SL_U, sl(SL_U), lt(K_10), PC_NONE);
            7'd71: u = uo(OP_DIV,  SL_U, sl(SL_U), sl(SL_V), PC_NONE);
            7'd72: u = uo(OP_WRP,  SL_U, sl(SL_U), sl(SL_U), PC_NONE);
            7'd73: u = uo(OP_SUB,  SL_T, sl(SL_T), sl(SL_U), PC_NONE);
            7'd74: u = uo(OP_CLI,  SL_T, sl(SL_T), sl(SL_T), PC_NONE);
            7'd75: u = uo(OP_LOOP, SL_T, sl(SL_T), sl(SL_T), PC_COLD_LOOP);
            7'd76: u = uo(OP_FIN,  SL_T, sl(SL_T), sl(SL_T), PC_NONE);
            default: u = uo(OP_FIN, SL_T, sl(SL_T), sl(SL_T), PC_NONE);
        endcase
        return u;
    endfunction

endpackage

// ===== hw/rtl/rtr_mul.sv =====
// Saturating 64x64 signed multiply, one multiplier bit per cycle, MSB first
module rtr_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_p
);
    import rtr_pkg::*;

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic        r_neg, r_ovf;
    logic [63:0] r_ua, r_ub, r_acc;
    logic [65:0] w_nxt, w_lim;

    // shift-add step with sticky overflow against the signed limit
    always_comb begin
        w_nxt = {1'b0, r_acc, 1'b0} + (r_ub[63] ? {2'b00, r_ua} : 66'd0);
        w_lim = r_neg ? {2'b00, 64'h8000_0000_0000_0000}
                      : {2'b00, 64'h7FFF_FFFF_FFFF_FFFF};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[63] ? 64'(-i_a) : i_a;
            r_ub  <= i_b[63] ? 64'(-i_b) : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_acc <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_ub <= {r_ub[62:0], 1'b0};
            if (w_nxt > w_lim) begin
                r_ovf <= 1'b1;
                r_acc <= 64'h8000_0000_0000_0000;
            end else begin
                r_acc <= w_nxt[63:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_ovf ? (r_neg ? S64_MIN : S64_MAX)
                          : (r_neg ? 64'(-r_acc) : r_acc);

endmodule

// ===== hw/rtl/rtr_div.sv =====
// Signed 64-bit divide truncating toward zero, restoring, one bit per cycle
module rtr_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    output logic               o_done,
    output logic signed [63:0] o_q
);
    import rtr_pkg::*;

    logic        r_busy, r_done;
    logic [5:0]  r_cnt;
    logic        r_neg, r_bz;
    logic [63:0] r_ub, r_dq, r_rem;
    logic [64:0] w_rem2, w_sub;
    logic        w_ge;

    // trial subtract
    always_comb begin
        w_rem2 = {r_rem, r_dq[63]};
        w_sub  = w_rem2 - {1'b0, r_ub};
        w_ge   = (w_rem2 >= {1'b0, r_ub});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd63);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: dividend shifts out while quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_a[63] ? 64'(-i_a) : i_a;
            r_ub  <= i_b[63] ? 64'(-i_b) : i_b;
            r_neg <= i_a[63] ^ i_b[63];
            r_bz  <= (i_b == '0);
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[63:0] : w_rem2[63:0];
            r_dq  <= {r_dq[62:0], w_ge};
        end
    end

    // zero divisor gives 0; a positive 2^63 quotient saturates
    always_comb begin
        if (r_bz) begin
            o_q = '0;
        end else if (r_neg) begin
            o_q = 64'(-r_dq);
        end else if (r_dq[63]) begin
            o_q = S64_MAX;
        end else begin
            o_q = r_dq;
        end
    end

    assign o_done = r_done;

endmodule

// ===== hw/rtl/rtr_core.sv =====
// Microcoded sequencer over a scratch memory, serial multiply and divide units
module rtr_core #(
    parameter int HOT_STEPS  = 4,
    parameter int COLD_STEPS = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [14:0]   i_code,
    input  rtr_pkg::t_cfg i_cfg,
    input  logic          i_out_free,
    output logic          o_busy,
    output rtr_pkg::t_res o_res
);
    import rtr_pkg::*;

    localparam int MaxSteps = (HOT_STEPS > COLD_STEPS) ? HOT_STEPS : COLD_STEPS;
    localparam int CntW     = $clog2(MaxSteps + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_OPER  = 4'b0100,
        ST_RUN   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [6:0]        r_pc, n_pc;
    logic [CntW-1:0]   r_cnt, n_cnt, w_cnt_dec;
    logic [14:0]       r_code;
    logic [30:0]       r_res;
    logic signed [63:0] r_rda, r_rdb;
    logic signed [63:0] r_mem [16];

    t_uop               w_uop;
    logic signed [63:0] w_opa, w_opb, w_alu, w_wdata;
    logic signed [64:0] w_sum, w_dif;
    logic signed [15:0] w_t16;
    logic [14:0]        w_fin_t;
    logic               w_we, w_res_we, w_fin_go, w_mul_go, w_div_go;
    logic               w_mul_done, w_div_done;
    logic signed [63:0] w_mul_p, w_div_q;

    function automatic logic signed [63:0] lit_val(t_lit k, t_cfg c,
                                                   logic [14:0] code);
        logic signed [63:0] v;
        case (k)
            K_CODE:  v = {49'd0, code};
            K_REF:   v = {48'd0, c.ref_ohms};
            K_DIV:   v = (c.full_scale == '0) ? 64'sd1 : {48'd0, c.full_scale};
            K_R0:    v = {44'd0, c.r0_x100};
            K_AH:    v = {33'd0, c.a_hot};
            K_BH:    v = {{43{c.b_hot[20]}}, c.b_hot};
            K_AC:    v = {37'd0, c.a_cold};
            K_BC:    v = {{36{c.b_cold[27]}}, c.b_cold};
            K_CC:    v = {{36{c.c_cold[27]}}, c.c_cold};
            K_2:     v = 64'sd2;
            K_4:     v = 64'sd4;
            K_10:    v = 64'sd10;
            K_100:   v = 64'sd100;
            K_1000:  v = 64'sd1000;
            K_3000:  v = 64'sd3000;
            K_10000: v = 64'sd10000;
            K_E8:    v = 64'sd100000000;
            K_E9:    v = 64'sd1000000000;
            K_E10:   v = 64'sd10000000000;
            K_E11:   v = 64'sd100000000000;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign w_uop = rtr_rom(r_pc);

    // operand select: literal or registered scratch read
    always_comb begin
        w_opa = w_uop.a.lit ? lit_val(t_lit'(w_uop.a.idx), i_cfg, r_code) : r_rda;
        w_opb = w_uop.b.lit ? lit_val(t_lit'(w_uop.b.idx), i_cfg, r_code) : r_rdb;
    end

    // combinational saturating add/sub, clamps and wrap
    always_comb begin
        w_sum = {w_opa[63], w_opa} + {w_opb[63], w_opb};
        w_dif = {w_opa[63], w_opa} - {w_opb[63], w_opb};
        case (w_uop.op)
            OP_ADD: w_alu = (w_sum[64] != w_sum[63])
                            ? (w_sum[64] ? S64_MIN : S64_MAX) : w_sum[63:0];
            OP_SUB: w_alu = (w_dif[64] != w_dif[63])
                            ? (w_dif[64] ? S64_MIN : S64_MAX) : w_dif[63:0];
            OP_CLR: w_alu = (w_opa < 0) ? 64'sd0
                            : ((w_opa > 64'sd8500) ? 64'sd8500 : w_opa);
            OP_CLI: w_alu = (w_opa < -64'sd2147483648) ? -64'sd2147483648
                            : ((w_opa > 64'sd2147483647) ? 64'sd2147483647 : w_opa);
            OP_WRP: w_alu = {{32{w_opa[31]}}, w_opa[31:0]};
            OP_CLRS: w_alu = (w_opa < 0) ? 64'sd0
                            : ((w_opa > 64'sd2147483647) ? 64'sd2147483647 : w_opa);
            default: w_alu = w_opa;
        endcase
    end

    // final 16-bit wrap and clamp to -200.0 .. 850.0 degrees
    always_comb begin
        w_t16 = w_opa[15:0];
        if (w_t16 < -16'sd2000) begin
            w_fin_t = 15'(-16'sd2000);
        end else if (w_t16 > 16'sd8500) begin
            w_fin_t = 15'(16'sd8500);
        end else begin
            w_fin_t = w_t16[14:0];
        end
    end

    assign w_cnt_dec = r_cnt - CntW'(1);

    // sequencer
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_cnt    = r_cnt;
        w_we     = 1'b0;
        w_wdata  = w_alu;
        w_res_we = 1'b0;
        w_fin_go = 1'b0;
        w_mul_go = 1'b0;
        w_div_go = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_pc    = '0;
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_OPER;
            end
            ST_OPER: begin
                n_state = ST_FETCH;
                n_pc    = r_pc + 7'd1;
                unique case (w_uop.op)
                    OP_MUL: begin
                        w_mul_go = 1'b1;
                        n_pc     = r_pc;
                        n_state  = ST_RUN;
                    end
                    OP_DIV: begin
                        w_div_go = 1'b1;
                        n_pc     = r_pc;
                        n_state  = ST_RUN;
                    end
                    OP_ADD, OP_SUB, OP_CLR, OP_CLI, OP_WRP: begin
                        w_we = 1'b1;
                    end
                    OP_CLRS: begin
                        w_we     = 1'b1;
                        w_res_we = 1'b1;
                    end
                    OP_BNEG: begin
                        if (w_opa < 0) begin
                            n_pc = w_uop.tgt;
                        end
                    end
                    OP_BZ: begin
                        if (w_opa == '0) begin
                            n_pc = w_uop.tgt;
                        end
                    end
                    OP_LHOT:  n_cnt = CntW'(HOT_STEPS);
                    OP_LCOLD: n_cnt = CntW'(COLD_STEPS);
                    OP_LOOP: begin
                        n_cnt = w_cnt_dec;
                        if (w_cnt_dec != '0) begin
                            n_pc = w_uop.tgt;
                        end
                    end
                    OP_FIN: begin
                        n_pc = r_pc;
                        if (i_out_free) begin
                            w_fin_go = 1'b1;
                            n_state  = ST_IDLE;
                        end else begin
                            n_state = ST_OPER;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_RUN: begin
                if (w_mul_done || w_div_done) begin
                    w_we    = 1'b1;
                    w_wdata = w_mul_done ? w_mul_p : w_div_q;
                    n_pc    = r_pc + 7'd1;
                    n_state = ST_FETCH;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_cnt   <= n_cnt;
        end
    end

    // scratch memory, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_uop.dst] <= w_wdata;
        end
        r_rda <= r_mem[w_uop.a.idx[3:0]];
        r_rdb <= r_mem[w_uop.b.idx[3:0]];
    end

    // item payload
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_code <= i_code;
        end
        if (w_res_we) begin
            r_res <= w_alu[30:0];
        end
    end

    rtr_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_go),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    rtr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_a     (w_opa),
        .i_b     (w_opb),
        .o_done  (w_div_done),
        .o_q     (w_div_q)
    );

    assign o_busy     = (r_state != ST_IDLE);
    assign o_res.done = w_fin_go;
    assign o_res.temp = w_fin_t;
    assign o_res.res  = r_res;

endmodule

// ===== hw/rtl/rtd_resistance_to_temperature.sv =====
// Channel  Dir  Handshake                   Payload
// in       in   i_in_valid / o_in_stall     i_rtd_word
// out      out  o_out_valid / i_out_stall   o_temperature_tenths, o_fault_seen,
//                                           o_resistance_x100
// cfg      in   i_cfg_we                    i_cfg_index, i_cfg_data
//
// One item at a time. Each 64-bit multiply or divide runs in the bit-serial
// units; every other micro-op passes through the fetch and operate states. A
// hot reading runs up to HOT_STEPS Newton steps, a cold one COLD_STEPS steps.
// o_in_stall is high from acceptance until the result is loaded into the
// output register; a result waiting under i_out_stall holds the next one back.
// Synchronous active-low reset restores the register defaults.
module rtd_resistance_to_temperature #(
    parameter int HOT_STEPS  = 4,
    parameter int COLD_STEPS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_rtd_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [14:0] o_temperature_tenths,
    output logic        o_fault_seen,
    output logic [30:0] o_resistance_x100,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [30:0] i_cfg_data
);
    import rtr_pkg::*;

    t_cfg        r_cfg;
    t_res        w_res;
    logic        w_busy, w_in_acc, w_out_free;
    logic        r_fault;
    logic        r_out_valid;
    logic [14:0] r_temp;
    logic        r_fault_out;
    logic [30:0] r_res_out;

    assign w_in_acc   = i_in_valid && !w_busy;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_ohms   <= RST_REF;
            r_cfg.full_scale <= RST_FS;
            r_cfg.r0_x100    <= RST_R0;
            r_cfg.a_hot      <= RST_A_HOT;
            r_cfg.b_hot      <= RST_B_HOT;
            r_cfg.a_cold     <= RST_A_COLD;
            r_cfg.b_cold     <= RST_B_COLD;
            r_cfg.c_cold     <= RST_C_COLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_REF:    r_cfg.ref_ohms   <= i_cfg_data[15:0];
                CFG_FS:     r_cfg.full_scale <= i_cfg_data[15:0];
                CFG_R0:     r_cfg.r0_x100    <= i_cfg_data[19:0];
                CFG_A_HOT:  r_cfg.a_hot      <= i_cfg_data[30:0];
                CFG_B_HOT:  r_cfg.b_hot      <= i_cfg_data[20:0];
                CFG_A_COLD: r_cfg.a_cold     <= i_cfg_data[26:0];
                CFG_B_COLD: r_cfg.b_cold     <= i_cfg_data[27:0];
                CFG_C_COLD: r_cfg.c_cold     <= i_cfg_data[27:0];
                default: ;
            endcase
        end
    end

    // fault flag travels alongside the item
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_fault <= i_rtd_word[0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.done) begin
            r_temp      <= w_res.temp;
            r_fault_out <= r_fault;
            r_res_out   <= w_res.res;
        end
    end

    rtr_core #(
        .HOT_STEPS  (HOT_STEPS),
        .COLD_STEPS (COLD_STEPS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_code     (i_rtd_word[15:1]),
        .i_cfg      (r_cfg),
        .i_out_free (w_out_free),
        .o_busy     (w_busy),
        .o_res      (w_res)
    );

    assign o_in_stall           = w_busy;
    assign o_out_valid          = r_out_valid;
    assign o_temperature_tenths = r_temp;
    assign o_fault_seen         = r_fault_out;
    assign o_resistance_x100    = r_res_out;

endmodule

// ===== hw/rtl/rtr_chk.sv =====
// Port-level checks on the converter
module rtr_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [14:0] o_temperature_tenths
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // an accepted item makes the block busy next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("no busy after accepting an item");

    // a new result only comes out of a conversion in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without an item");

    // temperature within the clamp range
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_temperature_tenths) >= -15'sd2000
                         && $signed(o_temperature_tenths) <= 15'sd8500))
        else $error("temperature out of range");

endmodule

bind rtd_resistance_to_temperature rtr_chk u_rtr_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_valid),
    .o_in_stall           (o_in_stall),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_temperature_tenths (o_temperature_tenths)
);
